@@ hdl/sst_pkg.sv @@
// Shared types and constants for the small set table.
// No dependencies; the interfaces, the cell and the core use this package.
package sst_pkg;

    // Operation codes carried in the request beat. The unused code acts as a query.
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // Field widths fixed by the request and response formats.
    localparam int OPCODE_W = 2;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;

    // Command broadcast from the core to every cell for the current beat.
    typedef struct packed {
        logic remove;   // remove beat: cells at or after the match take their neighbor
        logic append;   // add beat that stores the value at the tail
    } sst_cmd_t;

    // Per-cell position relative to the fill count.
    typedef struct packed {
        logic occupied; // cell index below the fill count
        logic tail;     // cell index equal to the fill count
    } sst_pos_t;

endpackage

@@ hdl/sst_if.sv @@
// Valid/ready channel interfaces for the small set table.
// Depends on sst_pkg for the field widths.
interface sst_req_if;
    logic                              valid;
    logic                              ready;
    logic [sst_pkg::OPCODE_W-1:0]      opcode;
    logic signed [sst_pkg::VALUE_W-1:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface sst_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic                         status;
    logic [sst_pkg::COUNT_W-1:0]  count;

    modport source (output valid, output found, output status, output count, input ready);
    modport sink   (input valid, input found, input status, input count, output ready);
endinterface

@@ hdl/sst_cell.sv @@
// One slot of the set table: holds an entry, compares it with the key and
// passes the remove-shift flag to the next cell. Depends on sst_pkg.
module sst_cell
(
    input  logic                          clk,
    input  logic                          load,
    input  logic [sst_pkg::VALUE_W-1:0]   key,
    input  logic [sst_pkg::VALUE_W-1:0]   upper_entry,
    input  sst_pkg::sst_cmd_t             cmd,
    input  sst_pkg::sst_pos_t             pos,
    input  logic                          shift_in,
    output logic                          shift_out,
    output logic [sst_pkg::VALUE_W-1:0]   entry
);

    logic [sst_pkg::VALUE_W-1:0] entry_reg;
    logic [sst_pkg::VALUE_W-1:0] entry_next;
    logic                        match;

    // An occupied entry equal to the key is a hit; the flag stays set for every later cell.
    assign match     = pos.occupied && (entry_reg == key);
    assign shift_out = shift_in || match;

    // On a remove, this cell and all cells after the hit take the upper neighbor.
    // On an append, the tail cell takes the key.
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.remove && shift_out)
        begin
            entry_next = upper_entry;
        end
        else if (cmd.append && pos.tail)
        begin
            entry_next = key;
        end
    end

    // Entry storage needs no reset; only occupied cells are ever compared.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

@@ hdl/small_set_table_core.sv @@
// Top level of the small set table: a row of cells plus the fill count and
// the response register. Depends on sst_pkg, sst_if and sst_cell.
//
// Usage:
//   req carries one operation per beat: opcode (add, remove, query) and a
//   32-bit value. rsp returns exactly one beat per request: found (value was
//   in the set before), status (1 when an add was dropped on a full set) and
//   count (entries held afterward, low 5 bits).
//   Latency: the response is valid in the cycle after the request beat.
//   Throughput: one request per cycle while rsp is not stalled. All cells
//   compare the key at once, and the hit flag ripples down the row so a remove
//   shifts later cells in the same cycle; the single response register sets the rate.
//   Stalls: while rsp holds an untaken beat, req.ready is low; it is high
//   again in the cycle the response is taken, so no cycle is lost.
//   Reset: rst_n (asynchronous, active low) empties the set and drops any
//   pending response. No clearing pass is needed: cells above the fill count
//   are never compared.
module small_set_table_core
#(
    parameter int CAPACITY = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    sst_req_if.sink    req,
    sst_rsp_if.source  rsp
);

    localparam int HELD_W = $clog2(CAPACITY + 1);

    logic [HELD_W-1:0]                 held_reg;
    logic [HELD_W-1:0]                 held_next;
    logic                              rsp_valid_reg;
    logic                              found_reg;
    logic                              status_reg;
    logic [sst_pkg::COUNT_W-1:0]       count_reg;

    logic                              accept;
    logic                              is_add;
    logic                              is_remove;
    logic                              full;
    logic                              found;
    logic                              dropped;
    sst_pkg::sst_cmd_t                 cmd;
    logic [CAPACITY:0]                 shift_chain;
    logic [sst_pkg::VALUE_W-1:0]       entry_w [CAPACITY];
    logic [31:0]                       held_ext;

    // Accept while the response register is empty or being drained.
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    // Decode the operation; any other code is a query.
    assign is_add    = (req.opcode == sst_pkg::OP_ADD);
    assign is_remove = (req.opcode == sst_pkg::OP_REMOVE);
    assign full      = (held_reg == HELD_W'(CAPACITY));
    assign found     = shift_chain[CAPACITY];
    assign dropped   = is_add && !found && full;

    assign cmd.remove = is_remove && found;
    assign cmd.append = is_add && !found && !full;

    // Row of cells; the hit flag enters at cell zero and leaves at the far end.
    assign shift_chain[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        sst_pkg::sst_pos_t           pos;
        logic [sst_pkg::VALUE_W-1:0] upper;

        assign pos.occupied = (HELD_W'(i) < held_reg);
        assign pos.tail     = (HELD_W'(i) == held_reg);

        if (i == CAPACITY - 1)
        begin : g_last
            assign upper = entry_w[i];
        end
        else
        begin : g_inner
            assign upper = entry_w[i + 1];
        end

        sst_cell u_cell
        (
            .clk         (clk),
            .load        (accept),
            .key         (req.value),
            .upper_entry (upper),
            .cmd         (cmd),
            .pos         (pos),
            .shift_in    (shift_chain[i]),
            .shift_out   (shift_chain[i + 1]),
            .entry       (entry_w[i])
        );
    end

    // Fill count after this beat.
    always_comb
    begin
        held_next = held_reg;
        if (cmd.append)
        begin
            held_next = held_reg + HELD_W'(1);
        end
        else if (cmd.remove)
        begin
            held_next = held_reg - HELD_W'(1);
        end
    end

    assign held_ext = 32'(held_next);

    // Fill count and response valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                held_reg <= held_next;
            end
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Response payload, loaded with each accepted beat.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            found_reg  <= found;
            status_reg <= dropped;
            count_reg  <= held_ext[sst_pkg::COUNT_W-1:0];
        end
    end

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.found  = found_reg;
    assign rsp.status = status_reg;
    assign rsp.count  = count_reg;

    // The fill count never passes the capacity.
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= HELD_W'(CAPACITY))
        else $error("fill count above capacity");

    // A response never reports both a hit and a dropped add.
    a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(found_reg && status_reg))
        else $error("found and dropped both set");

    // An accepted append grows the set by exactly one.
    a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.append) |=> (held_reg == $past(held_reg) + HELD_W'(1)))
        else $error("append did not grow the set by one");

    // A stalled response freezes the set contents' fill count.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp.ready) |=> $stable(held_reg))
        else $error("fill count changed during a stall");

endmodule

@@ tb/sst_tb_pkg.sv @@
`timescale 1ns / 1ps
// Scoreboard for the small set table testbench: response struct and a class
// that mirrors the set contents. Depends on sst_pkg for opcodes and widths.
package sst_tb_pkg;

    import sst_pkg::*;

    // Capacity the block is built with in this bench.
    localparam int SET_CAP = 16;

    // Spare opcode; the block treats it as a membership query.
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic               found;
        logic               status;
        logic [COUNT_W-1:0] count;
    } set_rsp_t;

    class set_response_board;
        logic [VALUE_W-1:0] members[SET_CAP];
        int unsigned        fill;
        set_rsp_t           expected_rsps[$];
        int                 mismatches;
        int                 checked;
        int                 drops;
        int                 shifts;
        int                 hits;
        int unsigned        peak_fill;

        function new();
            fill       = 0;
            mismatches = 0;
            checked    = 0;
            drops      = 0;
            shifts     = 0;
            hits       = 0;
            peak_fill  = 0;
        endfunction

        function int unsigned size();
            return fill;
        endfunction

        function logic [VALUE_W-1:0] member(int unsigned idx);
            return members[idx];
        endfunction

        function int outstanding();
            return expected_rsps.size();
        endfunction

        // Apply one accepted request to the mirrored set and queue the
        // response it must produce.
        function void note_request(logic [1:0] op, logic [VALUE_W-1:0] v);
            int unsigned slot;
            int unsigned j;
            set_rsp_t    rsp;

            // The first matching slot, or the fill count when there is none.
            slot = fill;
            for (int unsigned i = 0; i < fill; i++)
            begin
                if (slot == fill && members[i] == v)
                    slot = i;
            end
            rsp.found  = (slot < fill);
            rsp.status = 1'b0;

            if (op == OP_ADD && !rsp.found)
            begin
                if (fill >= SET_CAP)
                begin
                    rsp.status = 1'b1;
                    drops++;
                end
                else
                begin
                    members[fill] = v;
                    fill++;
                end
            end
            else if (op == OP_REMOVE && rsp.found)
            begin
                // Close the gap: every later entry moves down one place.
                if (slot + 1 < fill)
                    shifts++;
                for (j = slot; j + 1 < fill; j++)
                    members[j] = members[j + 1];
                fill--;
            end

            if (rsp.found)
                hits++;
            if (fill > peak_fill)
                peak_fill = fill;
            rsp.count = COUNT_W'(fill);
            expected_rsps.push_back(rsp);
        endfunction

        // Compare one accepted response beat with the oldest expectation.
        function void check_response(logic found, logic status, logic [COUNT_W-1:0] count);
            set_rsp_t want;

            checked++;
            if (expected_rsps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"response %0d arrived with nothing expected: ",
                              "found=%0b status=%0b count=%0d"},
                             checked, found, status, count);
                return;
            end
            want = expected_rsps.pop_front();
            if (want.found !== found || want.status !== status || want.count !== count)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"response %0d mismatch: ",
                              "expected found=%0b status=%0b count=%0d, ",
                              "got found=%0b status=%0b count=%0d"},
                             checked, want.found, want.status, want.count,
                             found, status, count);
            end
        endfunction
    endclass

endpackage

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Top-level testbench for small_set_table_core: drives request beats with
// random gaps and stalls, and checks every response against sst_tb_pkg.
module tb;

    import sst_pkg::*;
    import sst_tb_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int PHASES      = 10;
    localparam int PHASE_BEATS = 102;
    localparam int POOL_SIZE   = 20;
    localparam int LONG_HOLD   = 80;
    localparam int HOLD_AT     = 300;

    logic clk;
    logic rst_n;

    sst_req_if req_ch ();
    sst_rsp_if rsp_ch ();

    set_response_board  board;
    logic [VALUE_W-1:0] value_pool[POOL_SIZE];
    int                 sent_beats;
    int                 idle_cycles;
    bit                 no_idle;
    bit                 hold_done;

    small_set_table_core #(
        .CAPACITY(SET_CAP)
    ) u_top (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Length of an idle stretch: mostly none, some short, a few long.
    function automatic int unsigned idle_length();
        int unsigned r;
        if (no_idle)
            return 0;
        r = $urandom_range(99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(3, 1);
        return $urandom_range(30, 10);
    endfunction

    // Operation mix: add-heavy phases push the set to full, the others drain it.
    function automatic logic [1:0] pick_op(bit add_heavy);
        int unsigned r;
        r = $urandom_range(99);
        if (r < (add_heavy ? 60 : 25))
            return OP_ADD;
        if (r < 80)
            return OP_REMOVE;
        if (r < 95)
            return OP_QUERY;
        return OP_SPARE;
    endfunction

    // Removes mostly target a held value so the set really empties out.
    function automatic logic [VALUE_W-1:0] pick_value(logic [1:0] op);
        if (op == OP_REMOVE && board.size() > 0 && $urandom_range(99) < 60)
            return board.member($urandom_range(board.size() - 1));
        if ($urandom_range(99) < 8)
            return $urandom;
        return value_pool[$urandom_range(POOL_SIZE - 1)];
    endfunction

    // Offer one request beat, called at a falling edge. The valid stays high
    // after acceptance when no gap follows, so back-to-back beats are seamless.
    task automatic offer_op(input logic [1:0] op, input logic [VALUE_W-1:0] v);
        int unsigned gap;
        req_ch.valid  = 1'b1;
        req_ch.opcode = op;
        req_ch.value  = v;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        board.note_request(op, v);
        sent_beats++;
        @(negedge clk);
        gap = idle_length();
        if (gap > 0)
        begin
            req_ch.valid  = 1'b0;
            req_ch.opcode = 2'($urandom);
            req_ch.value  = $urandom;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Stop offering and wait until every expected response has come back.
    task automatic drain_results();
        req_ch.valid = 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Response side: random ready gaps, plus one long hold so the single
    // response register backs up into the request channel.
    initial
    begin
        int unsigned hold_len;
        rsp_ch.ready = 1'b0;
        hold_done    = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && sent_beats >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_len  = LONG_HOLD;
            end
            else
                hold_len = idle_length();
            if (hold_len == 0)
                rsp_ch.ready = 1'b1;
            else
            begin
                rsp_ch.ready = 1'b0;
                repeat (hold_len - 1) @(negedge clk);
            end
        end
    end

    // Response monitor and watchdog on cycles without any accepted beat.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                board.check_response(rsp_ch.found, rsp_ch.status, rsp_ch.count);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb failed");
                $finish;
            end
        end
    end

    // Stimulus: directed corner cases, then phases of random operations.
    initial
    begin
        logic [1:0] op;
        board         = new();
        rst_n         = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.opcode = OP_ADD;
        req_ch.value  = '0;
        sent_beats    = 0;
        idle_cycles   = 0;
        no_idle       = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Lookups and removes on the empty set.
        offer_op(OP_QUERY, 32'h0000_0000);
        offer_op(OP_REMOVE, 32'h0000_0005);
        // Extreme values, then an add of a value already held.
        offer_op(OP_ADD, 32'h8000_0000);
        offer_op(OP_ADD, 32'h7FFF_FFFF);
        offer_op(OP_ADD, 32'h0000_0000);
        offer_op(OP_ADD, 32'hFFFF_FFFF);
        offer_op(OP_ADD, 32'h5555_5555);
        offer_op(OP_ADD, 32'hAAAA_AAAA);
        offer_op(OP_ADD, 32'h7FFF_FFFF);
        offer_op(OP_QUERY, 32'h8000_0000);
        // The spare opcode must act as a query, hit and miss.
        offer_op(OP_SPARE, 32'h0000_0000);
        offer_op(OP_SPARE, 32'h1234_5678);
        // Fill to capacity, then adds on the full set.
        for (int i = 0; i < 10; i++)
            offer_op(OP_ADD, 32'h0000_0100 + i);
        offer_op(OP_ADD, 32'hDEAD_0001);
        offer_op(OP_ADD, 32'h7FFF_FFFF);
        // Removes at the head, in the middle and at the tail, then a miss.
        offer_op(OP_REMOVE, 32'h8000_0000);
        offer_op(OP_REMOVE, 32'h5555_5555);
        offer_op(OP_REMOVE, 32'h0000_0109);
        offer_op(OP_REMOVE, 32'h0000_0109);
        drain_results();

        // Random phases alternate between filling and draining the set. A new
        // value pool comes in with each filling phase.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            no_idle = (phase == 1 || phase == 6);
            if (phase % 2 == 0)
            begin
                for (int i = 0; i < POOL_SIZE; i++)
                    value_pool[i] = $urandom;
                value_pool[0] = 32'h8000_0000;
                value_pool[1] = 32'h7FFF_FFFF;
            end
            for (int k = 0; k < PHASE_BEATS; k++)
            begin
                op = pick_op(phase % 2 == 0);
                offer_op(op, pick_value(op));
            end
            drain_results();
        end

        repeat (5) @(posedge clk);
        $display("Checked %0d responses for %0d requests; %0d adds were dropped on a full set.",
                 board.checked, sent_beats, board.drops);
        $display("%0d removes shifted later entries, %0d operations hit, peak fill %0d of %0d.",
                 board.shifts, board.hits, board.peak_fill, SET_CAP);
        if (board.mismatches == 0 && board.outstanding() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
